>>> design/mhp_pkg.sv
// ----------------------------------------------------------------------------
// Multiplicative hash partitioner package
// Shared widths, constants, codes and types of the partitioner.
// ----------------------------------------------------------------------------
package mhp_pkg;

  localparam int MAX_HASH_BITS = 8;
  localparam int SLOT_BITS     = 16;
  localparam int NPART         = 1 << MAX_HASH_BITS;
  localparam int PART_W        = MAX_HASH_BITS;
  localparam int CNT_W         = SLOT_BITS + 1;
  localparam int HB_W          = 4;
  localparam int KEY_W         = 64;
  localparam int CFG_IDX_W     = 2;
  localparam int CFG_DATA_W    = 17;

  // Golden-ratio fraction in unsigned Q0.64.
  localparam logic [63:0] GOLDEN_Q64 = 64'h9E37_79B9_7F4A_7C15;

  localparam logic [1:0] OP_PLACE = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_HASH_WIDTH = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY   = CFG_IDX_W'(1);

  typedef struct packed {
    logic              rd_en;
    logic [PART_W-1:0] rd_addr;
    logic              wr_en;
    logic [PART_W-1:0] wr_addr;
    logic [CNT_W-1:0]  wr_data;
    logic              clr_all;
  } mem_req_t;

endpackage

>>> design/mhp_in_if.sv
// ----------------------------------------------------------------------------
// Partitioner input channel
// Valid/ready channel carrying one tuple or command word.
// ----------------------------------------------------------------------------
interface mhp_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [63:0] tuple_key;
  logic [63:0] tuple_payload;
  logic [7:0]  partition_select;

  modport source (output valid, opcode, tuple_key, tuple_payload, partition_select,
                  input ready);
  modport sink (input valid, opcode, tuple_key, tuple_payload, partition_select,
                output ready);
endinterface

>>> design/mhp_out_if.sv
// ----------------------------------------------------------------------------
// Partitioner result channel
// Valid/ready channel carrying one result word.
// ----------------------------------------------------------------------------
interface mhp_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  dest_partition;
  logic [15:0] dest_slot;
  logic [63:0] out_key;
  logic [63:0] out_payload;
  logic [16:0] fill_count;
  logic        overflow;

  modport source (output valid, dest_partition, dest_slot, out_key, out_payload,
                  fill_count, overflow, input ready);
  modport sink (input valid, dest_partition, dest_slot, out_key, out_payload,
                fill_count, overflow, output ready);
endinterface

>>> design/mhp_cfg_if.sv
// ----------------------------------------------------------------------------
// Partitioner configuration channel
// Valid/ready register write channel: register index and write data.
// ----------------------------------------------------------------------------
interface mhp_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [16:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

>>> design/mhp_hash.sv
// ----------------------------------------------------------------------------
// Multiplicative hash unit
// Key times the golden-ratio fraction, split into 32-bit partial products.
// One register stage of products, then the high-word add and bit select.
// ----------------------------------------------------------------------------
module mhp_hash
  import mhp_pkg::*;
(
  input  logic              clk,
  input  logic [KEY_W-1:0]  key,
  input  logic [HB_W-1:0]   hash_width,
  output logic [PART_W-1:0] part
);

  logic [31:0] kl, kh, gl, gh;
  logic [63:0] p0_nxt, p0_r;
  logic [31:0] p1_nxt, p1_r;
  logic [31:0] p2_nxt, p2_r;
  logic [31:0] hi_word;
  logic [PART_W-1:0] top_bits;
  logic [HB_W-1:0]   eff_bits;

  assign kl = key[31:0];
  assign kh = key[63:32];
  assign gl = GOLDEN_Q64[31:0];
  assign gh = GOLDEN_Q64[63:32];

  // Only the low 32 bits of the cross products reach the high product word.
  assign p0_nxt = 64'(kl) * 64'(gl);
  assign p1_nxt = 32'(kh * gl);
  assign p2_nxt = 32'(kl * gh);

  always_ff @(posedge clk) begin
    p0_r <= p0_nxt;
    p1_r <= p1_nxt;
    p2_r <= p2_nxt;
  end

  assign hi_word  = p0_r[63:32] + p1_r + p2_r;
  assign top_bits = hi_word[31 -: PART_W];
  assign eff_bits = (hash_width > HB_W'(MAX_HASH_BITS)) ? HB_W'(MAX_HASH_BITS) : hash_width;

  always_comb begin
    if (eff_bits == '0) begin
      part = '0;
    end else begin
      part = top_bits >> (HB_W'(MAX_HASH_BITS) - eff_bits);
    end
  end

endmodule

>>> design/mhp_count_mem.sv
// ----------------------------------------------------------------------------
// Fill counter store
// Synchronous counter memory with a registered read, plus a valid bit
// per partition. An entry that is not valid reads as zero.
// ----------------------------------------------------------------------------
module mhp_count_mem
  import mhp_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  mem_req_t         req,
  output logic [CNT_W-1:0] rd_count
);

  logic [CNT_W-1:0] mem [NPART];
  logic [NPART-1:0] valid_r;
  logic [CNT_W-1:0] rd_data_r;
  logic             rd_valid_r;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_data_r <= mem[req.rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= '0;
      rd_valid_r <= 1'b0;
    end else begin
      if (req.clr_all) begin
        valid_r <= '0;
      end else if (req.wr_en) begin
        valid_r[req.wr_addr] <= 1'b1;
      end
      if (req.rd_en) begin
        rd_valid_r <= valid_r[req.rd_addr];
      end
    end
  end

  assign rd_count = rd_valid_r ? rd_data_r : '0;

endmodule

>>> design/multiplicative_hash_partitioner_unit.sv
// ----------------------------------------------------------------------------
// Multiplicative hash partitioner
// Each word runs through S_MUL, S_HASH, S_RMW and S_DONE in turn (hash multiply,
// counter read, read-modify-write and output load); a new input word is accepted
// only in S_IDLE, once the previous word has loaded the output register.
// Reset: counters read as empty, hash width = 4, partition_capacity = 65536.
// ----------------------------------------------------------------------------
module multiplicative_hash_partitioner_unit
  import mhp_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  mhp_cfg_if.sink  cfg_chan,
  mhp_in_if.sink   in_chan,
  mhp_out_if.source out_chan
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL  = 3'd1;
  localparam logic [2:0] S_HASH = 3'd2;
  localparam logic [2:0] S_RMW  = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  localparam logic [CNT_W-1:0] CAP_LIMIT = CNT_W'(1) << SLOT_BITS;

  logic [2:0] state_r, state_nxt;

  logic [HB_W-1:0]  hash_width_r;
  logic [CNT_W-1:0] capacity_r;
  logic [CNT_W-1:0] cap_eff;

  logic [1:0]        op_r;
  logic [KEY_W-1:0]  key_r;
  logic [KEY_W-1:0]  payload_r;
  logic [PART_W-1:0] sel_r;
  logic [PART_W-1:0] addr_r;

  logic [PART_W-1:0] hash_part;
  logic [PART_W-1:0] rd_addr;
  logic [CNT_W-1:0]  rd_count;
  logic [CNT_W-1:0]  cnt_inc;
  logic              has_room;
  mem_req_t          mem_req;

  logic [PART_W-1:0]    res_part_r,  res_part_nxt;
  logic [SLOT_BITS-1:0] res_slot_r,  res_slot_nxt;
  logic [KEY_W-1:0]     res_key_r,   res_key_nxt;
  logic [KEY_W-1:0]     res_pay_r,   res_pay_nxt;
  logic [CNT_W-1:0]     res_fill_r,  res_fill_nxt;
  logic                 res_ovf_r,   res_ovf_nxt;

  logic                 out_valid_r;
  logic [PART_W-1:0]    out_part_r;
  logic [SLOT_BITS-1:0] out_slot_r;
  logic [KEY_W-1:0]     out_key_r;
  logic [KEY_W-1:0]     out_pay_r;
  logic [CNT_W-1:0]     out_fill_r;
  logic                 out_ovf_r;
  logic                 out_free;

  // Configuration registers.
  assign cfg_chan.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hash_width_r <= HB_W'(4);
      capacity_r   <= CAP_LIMIT;
    end else if (cfg_chan.valid) begin
      case (cfg_chan.index)
        CFG_HASH_WIDTH: hash_width_r <= cfg_chan.data[HB_W-1:0];
        CFG_CAPACITY:   capacity_r   <= cfg_chan.data[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  assign cap_eff = (capacity_r > CAP_LIMIT) ? CAP_LIMIT : capacity_r;

  mhp_hash u_hash (
    .clk        (clk),
    .key        (key_r),
    .hash_width (hash_width_r),
    .part       (hash_part)
  );

  mhp_count_mem u_mem (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (mem_req),
    .rd_count (rd_count)
  );

  // Sequencer.
  assign in_chan.ready = (state_r == S_IDLE);
  assign out_free      = !out_valid_r || out_chan.ready;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (in_chan.valid) state_nxt = S_MUL;
      S_MUL:   state_nxt = S_HASH;
      S_HASH:  state_nxt = S_RMW;
      S_RMW:   state_nxt = S_DONE;
      S_DONE:  if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_chan.valid && in_chan.ready) begin
      op_r      <= in_chan.opcode;
      key_r     <= in_chan.tuple_key;
      payload_r <= in_chan.tuple_payload;
      sel_r     <= in_chan.partition_select[PART_W-1:0];
    end
    if (state_r == S_HASH) begin
      addr_r <= rd_addr;
    end
  end

  // Read-modify-write of the counter memory.
  assign rd_addr  = (op_r == OP_PLACE) ? hash_part : sel_r;
  assign has_room = rd_count < cap_eff;
  assign cnt_inc  = rd_count + CNT_W'(1);

  always_comb begin
    mem_req.rd_en   = (state_r == S_HASH);
    mem_req.rd_addr = rd_addr;
    mem_req.wr_en   = (state_r == S_RMW) && (op_r == OP_PLACE) && has_room;
    mem_req.wr_addr = addr_r;
    mem_req.wr_data = cnt_inc;
    mem_req.clr_all = (state_r == S_RMW) && (op_r == OP_CLEAR);
  end

  always_comb begin
    res_part_nxt = '0;
    res_slot_nxt = '0;
    res_key_nxt  = '0;
    res_pay_nxt  = '0;
    res_fill_nxt = '0;
    res_ovf_nxt  = 1'b0;
    case (op_r)
      OP_PLACE: begin
        res_part_nxt = addr_r;
        res_key_nxt  = key_r;
        res_pay_nxt  = payload_r;
        if (has_room) begin
          res_slot_nxt = rd_count[SLOT_BITS-1:0];
          res_fill_nxt = cnt_inc;
        end else begin
          res_fill_nxt = rd_count;
          res_ovf_nxt  = 1'b1;
        end
      end
      OP_READ: begin
        res_part_nxt = addr_r;
        res_fill_nxt = rd_count;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (state_r == S_RMW) begin
      res_part_r <= res_part_nxt;
      res_slot_r <= res_slot_nxt;
      res_key_r  <= res_key_nxt;
      res_pay_r  <= res_pay_nxt;
      res_fill_r <= res_fill_nxt;
      res_ovf_r  <= res_ovf_nxt;
    end
  end

  // Output register; it is loaded only once the previous word has left.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == S_DONE && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_DONE && out_free) begin
      out_part_r <= res_part_r;
      out_slot_r <= res_slot_r;
      out_key_r  <= res_key_r;
      out_pay_r  <= res_pay_r;
      out_fill_r <= res_fill_r;
      out_ovf_r  <= res_ovf_r;
    end
  end

  assign out_chan.valid          = out_valid_r;
  assign out_chan.dest_partition = out_part_r;
  assign out_chan.dest_slot      = out_slot_r;
  assign out_chan.out_key        = out_key_r;
  assign out_chan.out_payload    = out_pay_r;
  assign out_chan.fill_count     = out_fill_r;
  assign out_chan.overflow       = out_ovf_r;

endmodule

>>> tb/multiplicative_hash_partitioner_unit_test.sv
// ----------------------------------------------------------------------------
// Multiplicative hash partitioner testbench
// Drives tuple, read, clear and unused words through the partitioner under
// several register settings. Every result word is compared with a scripted route
// or a local copy of the fill counters and the golden-ratio hash. Both sides stall
// at random, and the receiver twice blocks for a long stretch to back up the block.
// ----------------------------------------------------------------------------
module multiplicative_hash_partitioner_unit_test;
  import mhp_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = CFG_IDX_W'(3);
  localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam int SETTLE_CYCLES = 8;
  localparam int LONG_HOLD = 300;
  localparam int STALL_LIMIT = 3000;
  localparam int PHASE_WORDS = 240;
  localparam int NUM_PHASES = 6;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [63:0] key;
    logic [63:0] payload;
    logic [7:0]  sel;
  } tuple_word_t;

  typedef struct packed {
    logic [7:0]       part;
    logic [15:0]      slot;
    logic [63:0]      key;
    logic [63:0]      payload;
    logic [CNT_W-1:0] fill;
    logic             ovf;
  } route_t;

  typedef struct {
    bit                       is_reg;
    tuple_word_t              word;
    logic [CFG_IDX_W-1:0]     reg_idx;
    logic [CFG_DATA_W-1:0]    reg_data;
    bit                       typed;
    route_t                   route;
  } script_row_t;

  logic clk = 1'b0;
  logic rst_n;

  mhp_cfg_if cfg_chan ();
  mhp_in_if  in_chan ();
  mhp_out_if out_chan ();

  multiplicative_hash_partitioner_unit DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_chan (cfg_chan),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  always #1 clk = ~clk;

  // Local copy of the block's registers and counters.
  logic [HB_W-1:0]  hash_width = HB_W'(4);
  logic [CNT_W-1:0] capacity = CNT_W'(65536);
  logic [CNT_W-1:0] fill_cnt [NPART];
  bit               fill_valid [NPART];

  route_t      awaited_routes [$];
  int          bad_routes = 0;
  int          quiet_cycles = 0;
  int unsigned snd_idle = 0;
  int unsigned rcv_idle = 0;
  int          holds_asked = 0;
  int          holds_done = 0;
  logic [63:0] key_pool [6];
  script_row_t script [$];

  function automatic int unsigned used_hash_width();
    return (hash_width > MAX_HASH_BITS) ? MAX_HASH_BITS : int'(hash_width);
  endfunction

  function automatic route_t route_tuple(tuple_word_t w);
    route_t           r;
    logic [63:0]      frac;
    logic [PART_W-1:0] p;
    logic [CNT_W-1:0] cnt;
    logic [CNT_W-1:0] cap;
    int unsigned      b;
    r = '0;
    case (w.opcode)
      OP_PLACE: begin
        frac = w.key * GOLDEN_Q64;
        b = used_hash_width();
        p = (b == 0) ? '0 : PART_W'(frac >> (64 - b));
        cnt = fill_valid[p] ? fill_cnt[p] : '0;
        cap = (capacity > CNT_W'(1 << SLOT_BITS)) ? CNT_W'(1 << SLOT_BITS) : capacity;
        r.part = p;
        r.key = w.key;
        r.payload = w.payload;
        if (cnt < cap) begin
          r.slot = cnt[15:0];
          cnt = cnt + 1'b1;
          fill_cnt[p] = cnt;
          fill_valid[p] = 1'b1;
          r.fill = cnt;
        end else begin
          r.fill = cnt;
          r.ovf = 1'b1;
        end
      end
      OP_READ: begin
        p = w.sel;
        r.part = p;
        r.fill = fill_valid[p] ? fill_cnt[p] : '0;
      end
      OP_CLEAR: begin
        foreach (fill_valid[i]) fill_valid[i] = 1'b0;
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic script_row_t item(tuple_word_t w);
    script_row_t row;
    row = '{default: '0};
    row.word = w;
    return row;
  endfunction

  function automatic script_row_t item_typed(tuple_word_t w, route_t r);
    script_row_t row;
    row = item(w);
    row.typed = 1'b1;
    row.route = r;
    return row;
  endfunction

  function automatic script_row_t reg_row(logic [CFG_IDX_W-1:0] idx,
                                          logic [CFG_DATA_W-1:0] value);
    script_row_t row;
    row = '{default: '0};
    row.is_reg = 1'b1;
    row.reg_idx = idx;
    row.reg_data = value;
    return row;
  endfunction

  function automatic tuple_word_t random_word();
    tuple_word_t w;
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 72)      w.opcode = OP_PLACE;
    else if (pick < 92) w.opcode = OP_READ;
    else if (pick < 96) w.opcode = OP_UNUSED;
    else                w.opcode = OP_CLEAR;
    // Repeated keys from a small pool drive partitions toward full.
    case ($urandom_range(9))
      0, 1, 2, 3: w.key = key_pool[$urandom_range(5)];
      4:          w.key = $urandom_range(1) ? ALL_ONES : 64'h0;
      5:          w.key = 64'd1 << $urandom_range(63);
      default:    w.key = {$urandom, $urandom};
    endcase
    case ($urandom_range(9))
      0:       w.payload = 64'h0;
      1:       w.payload = ALL_ONES;
      default: w.payload = {$urandom, $urandom};
    endcase
    if ($urandom_range(1))
      w.sel = 8'($urandom_range((1 << used_hash_width()) - 1));
    else
      w.sel = 8'($urandom_range(255));
    return w;
  endfunction

  // Waits until every outstanding result word has come back, then lets the
  // pipeline settle.
  task automatic drain_results();
    in_chan.valid <= 1'b0;
    while (awaited_routes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] value);
    drain_results();
    cfg_chan.valid <= 1'b1;
    cfg_chan.index <= idx;
    cfg_chan.data  <= value;
    @(posedge clk);
    while (!cfg_chan.ready) @(posedge clk);
    cfg_chan.valid <= 1'b0;
    case (idx)
      CFG_HASH_WIDTH: hash_width = value[HB_W-1:0];
      CFG_CAPACITY:   capacity = value;
      default: ;
    endcase
  endtask

  task automatic send_word(input tuple_word_t w, input bit typed, input route_t route);
    route_t model_route;
    while ($urandom_range(99) < snd_idle) begin
      in_chan.valid <= 1'b0;
      @(posedge clk);
    end
    in_chan.valid            <= 1'b1;
    in_chan.opcode           <= w.opcode;
    in_chan.tuple_key        <= w.key;
    in_chan.tuple_payload    <= w.payload;
    in_chan.partition_select <= w.sel;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    model_route = route_tuple(w);
    awaited_routes.push_back(typed ? route : model_route);
  endtask

  // Receiver: random stalls, plus a long hold whenever one is requested.
  initial begin
    out_chan.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (holds_asked != holds_done) begin
        holds_done++;
        out_chan.ready <= 1'b0;
        repeat (LONG_HOLD - 1) @(posedge clk);
      end else begin
        out_chan.ready <= ($urandom_range(99) >= rcv_idle);
      end
    end
  end

  always @(posedge clk) begin
    route_t got;
    route_t want;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      got = '{out_chan.dest_partition, out_chan.dest_slot, out_chan.out_key,
              out_chan.out_payload, out_chan.fill_count, out_chan.overflow};
      if (awaited_routes.size() == 0) begin
        bad_routes++;
        if (bad_routes <= 10)
          $display("unexpected result word: part=%0d slot=%0d fill=%0d ovf=%b",
                   got.part, got.slot, got.fill, got.ovf);
      end else begin
        want = awaited_routes.pop_front();
        if (got !== want) begin
          bad_routes++;
          if (bad_routes <= 10) begin
            $display("result mismatch: expected part=%0d slot=%0d key=%h payload=%h fill=%0d ovf=%b",
                     want.part, want.slot, want.key, want.payload, want.fill, want.ovf);
            $display("                 actual   part=%0d slot=%0d key=%h payload=%h fill=%0d ovf=%b",
                     got.part, got.slot, got.key, got.payload, got.fill, got.ovf);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready) ||
        (cfg_chan.valid && cfg_chan.ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    int unsigned phase_hb [NUM_PHASES];
    int unsigned phase_cap [NUM_PHASES];
    phase_hb = '{4, 0, 8, 1, 15, 3};
    phase_cap = '{65536, 7, 2, 40, 131071, 5};

    rst_n                    <= 1'b0;
    cfg_chan.valid           <= 1'b0;
    cfg_chan.index           <= '0;
    cfg_chan.data            <= '0;
    in_chan.valid            <= 1'b0;
    in_chan.opcode           <= '0;
    in_chan.tuple_key        <= '0;
    in_chan.tuple_payload    <= '0;
    in_chan.partition_select <= '0;
    foreach (fill_valid[i]) fill_valid[i] = 1'b0;

    // Reset state: hash width 4, capacity 65536, all counters empty.
    script.push_back(item_typed('{OP_READ, 64'h0, 64'h0, 8'd0},
                                '{8'd0, 16'd0, 64'h0, 64'h0, 17'd0, 1'b0}));
    script.push_back(item_typed('{OP_READ, ALL_ONES, ALL_ONES, 8'hFF},
                                '{8'hFF, 16'd0, 64'h0, 64'h0, 17'd0, 1'b0}));
    script.push_back(item_typed('{OP_PLACE, 64'h0, ALL_ONES, 8'hFF},
                                '{8'd0, 16'd0, 64'h0, ALL_ONES, 17'd1, 1'b0}));
    script.push_back(item_typed('{OP_PLACE, 64'h0, 64'h0, 8'd0},
                                '{8'd0, 16'd1, 64'h0, 64'h0, 17'd2, 1'b0}));
    script.push_back(item_typed('{OP_READ, 64'h0, 64'h0, 8'd0},
                                '{8'd0, 16'd0, 64'h0, 64'h0, 17'd2, 1'b0}));
    script.push_back(item('{OP_PLACE, ALL_ONES, 64'h5555_5555_5555_5555, 8'd0}));
    script.push_back(item('{OP_PLACE, 64'h1, 64'hAAAA_AAAA_AAAA_AAAA, 8'd0}));
    script.push_back(item_typed('{OP_UNUSED, ALL_ONES, ALL_ONES, 8'hFF}, '0));
    script.push_back(item_typed('{OP_CLEAR, ALL_ONES, ALL_ONES, 8'hFF}, '0));
    script.push_back(item_typed('{OP_READ, 64'h0, 64'h0, 8'd0}, '0));
    // With zero hash bits every key lands in partition 0.
    script.push_back(reg_row(CFG_HASH_WIDTH, 17'h1FFF0));
    script.push_back(item_typed('{OP_PLACE, ALL_ONES, 64'h1, 8'd0},
                                '{8'd0, 16'd0, ALL_ONES, 64'h1, 17'd1, 1'b0}));
    script.push_back(item_typed('{OP_PLACE, 64'h8000_0000_0000_0000, 64'h2, 8'd0},
                                '{8'd0, 16'd1, 64'h8000_0000_0000_0000, 64'h2, 17'd2, 1'b0}));
    // A hash width above the maximum behaves as the maximum.
    script.push_back(reg_row(CFG_HASH_WIDTH, 17'd15));
    script.push_back(item('{OP_PLACE, 64'h1, 64'h3, 8'd0}));
    script.push_back(item('{OP_PLACE, 64'hFEDC_BA98_7654_3210, 64'h0123_4567_89AB_CDEF, 8'd0}));
    script.push_back(reg_row(CFG_CAPACITY, 17'd0));
    script.push_back(item('{OP_PLACE, 64'h0, 64'h4, 8'd0}));
    script.push_back(reg_row(CFG_UNUSED, 17'h1FFFF));
    script.push_back(reg_row(CFG_CAPACITY, 17'h1FFFF));
    script.push_back(item('{OP_PLACE, 64'h0, 64'h5, 8'd0}));
    script.push_back(reg_row(CFG_CAPACITY, 17'd3));
    script.push_back(item('{OP_PLACE, 64'h0, 64'h6, 8'd0}));
    script.push_back(item('{OP_READ, 64'h0, 64'h0, 8'd0}));

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    snd_idle = 16;
    rcv_idle = 45;
    foreach (script[i]) begin
      if (script[i].is_reg)
        write_register(script[i].reg_idx, script[i].reg_data);
      else
        send_word(script[i].word, script[i].typed, script[i].route);
    end

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      if (ph < 2) begin
        snd_idle = 16;
        rcv_idle = 45;
      end else if (ph < 4) begin
        snd_idle = 45;
        rcv_idle = 16;
      end else begin
        snd_idle = 0;
        rcv_idle = 0;
      end
      write_register(CFG_HASH_WIDTH, {13'($urandom), 4'(phase_hb[ph])});
      write_register(CFG_CAPACITY, 17'(phase_cap[ph]));
      foreach (key_pool[k]) key_pool[k] = {$urandom, $urandom};
      // Block the receiver for a while so the block backs up and stalls its input.
      if (ph == 1 || ph == 4) holds_asked++;
      repeat (PHASE_WORDS) send_word(random_word(), 1'b0, '0);
    end

    drain_results();
    if (bad_routes == 0 && awaited_routes.size() == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule

>>> filelist.f
design/mhp_pkg.sv
design/mhp_in_if.sv
design/mhp_out_if.sv
design/mhp_cfg_if.sv
design/mhp_hash.sv
design/mhp_count_mem.sv
design/multiplicative_hash_partitioner_unit.sv
tb/multiplicative_hash_partitioner_unit_test.sv
